// ===== src/lbvs_pkg.sv =====
// shared constants and saturation helpers for the vertex skinning block
// no dependencies
package lbvs_pkg;

    localparam int BONE_COUNT_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORDS_PER_BONE = 12;
    localparam int INFLUENCES     = 4;
    localparam int WEIGHT_BITS    = 15;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    // clamp a 36-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32_36(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > 36'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // clamp a 66-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32_66(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/lbvs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lbvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/linear_blend_vertex_skinning.sv =====
// linear blend skinning, four influences, five-stage pipeline
// depends on lbvs_pkg and lbvs_ram
//
// Accepts one transfer per clock while s_ready is high. A palette transfer
// (op 0) writes one Q16.16 matrix word at once and makes no result; an
// out-of-range address is dropped. A vertex transfer (op 1) gives one result
// through palette read, weight multiply, blend sum with saturation,
// matrix-vector multiply, final sum with saturation. The palette is held in
// 48 bone-deep rams, one per influence and matrix word, all read at once.
// Palette words must be written before a vertex uses them. A stall on the
// result side stops only the stages that are full.
module linear_blend_vertex_skinning #(
    parameter int BONE_COUNT = lbvs_pkg::BONE_COUNT_DEF,
    parameter int FRAC_BITS  = lbvs_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [9:0]         s_palette_addr,
    input  logic signed [31:0] s_palette_value,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_nrm_x,
    input  logic signed [31:0] s_nrm_y,
    input  logic signed [31:0] s_nrm_z,
    input  logic [23:0]        s_bone_ids,
    input  logic [62:0]        s_blend_weights,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_pos_x,
    output logic signed [31:0] m_out_pos_y,
    output logic signed [31:0] m_out_pos_z,
    output logic signed [31:0] m_out_nrm_x,
    output logic signed [31:0] m_out_nrm_y,
    output logic signed [31:0] m_out_nrm_z
);

    localparam int AW  = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int NW  = lbvs_pkg::WORDS_PER_BONE;
    localparam int NI  = lbvs_pkg::INFLUENCES;
    localparam int WB  = lbvs_pkg::WEIGHT_BITS;
    localparam int NST = 5;

    // stage valids and per-stage enables
    logic [NST:1] v_reg;
    logic [NST:1] en;

    always_comb begin
        en[NST] = !v_reg[NST] || m_ready;
        for (int i = NST - 1; i >= 1; i--) begin
            en[i] = !v_reg[i] || en[i + 1];
        end
    end

    assign s_ready = en[1];

    logic acc;
    assign acc = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) begin
                v_reg[1] <= acc && (s_op == lbvs_pkg::OP_VERTEX);
            end
            for (int i = 2; i <= NST; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    // palette write address split: bone = addr/12, word = addr%12
    logic [19:0]   div_prod;
    logic [6:0]    wr_bone;
    logic [3:0]    wr_word;
    logic          wr_ok;
    logic          wr_en;

    assign div_prod = 20'(s_palette_addr) * 20'd683;
    assign wr_bone  = div_prod[19:13];
    assign wr_word  = 4'(s_palette_addr - (10'(wr_bone) * 10'd12));
    assign wr_ok    = ({2'b00, s_palette_addr} < 12'(BONE_COUNT * NW));
    assign wr_en    = acc && (s_op == lbvs_pkg::OP_WRITE) && wr_ok;

    // read addresses and in-range flags for each influence
    logic [AW-1:0] rd_addr [NI];
    logic [NI-1:0] id_ok;

    always_comb begin
        for (int k = 0; k < NI; k++) begin
            rd_addr[k] = AW'(s_bone_ids[6*k +: 6]);
            id_ok[k]   = ({3'b000, s_bone_ids[6*k +: 6]} < 9'(BONE_COUNT));
        end
    end

    // palette rams
    logic [31:0] pal_rd [NI][NW];

    for (genvar k = 0; k < NI; k++) begin : g_infl
        for (genvar e = 0; e < NW; e++) begin : g_word
            lbvs_ram #(
                .WIDTH(32),
                .DEPTH(BONE_COUNT),
                .AW   (AW)
            ) u_ram (
                .aclk (aclk),
                .we   (wr_en && (wr_word == 4'(e))),
                .waddr(AW'(wr_bone)),
                .wdata(s_palette_value),
                .re   (en[1]),
                .raddr(rd_addr[k]),
                .rdata(pal_rd[k][e])
            );
        end
    end

    // stage 1 side data
    logic signed [31:0] pos1_reg [3];
    logic signed [31:0] nrm1_reg [3];
    logic [15:0]        w1_reg   [NI];
    logic [NI-1:0]      ok1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pos1_reg[0] <= s_pos_x;
            pos1_reg[1] <= s_pos_y;
            pos1_reg[2] <= s_pos_z;
            nrm1_reg[0] <= s_nrm_x;
            nrm1_reg[1] <= s_nrm_y;
            nrm1_reg[2] <= s_nrm_z;
            for (int k = 0; k < NI - 1; k++) begin
                w1_reg[k] <= s_blend_weights[16*k +: 16];
            end
            w1_reg[NI-1] <= {1'b0, s_blend_weights[62:48]};
            ok1_reg      <= id_ok;
        end
    end

    // stage 2: weight times palette word, floor shift by weight fraction, zero for out-of-range ids
    logic signed [48:0] wprod [NI][NW];
    logic signed [33:0] wsh2_reg [NI][NW];
    logic signed [31:0] pos2_reg [3];
    logic signed [31:0] nrm2_reg [3];

    always_comb begin
        for (int k = 0; k < NI; k++) begin
            for (int e = 0; e < NW; e++) begin
                wprod[k][e] = $signed({1'b0, w1_reg[k]}) * $signed(pal_rd[k][e]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int k = 0; k < NI; k++) begin
                for (int e = 0; e < NW; e++) begin
                    wsh2_reg[k][e] <= ok1_reg[k] ? wprod[k][e][48:WB] : '0;
                end
            end
            pos2_reg <= pos1_reg;
            nrm2_reg <= nrm1_reg;
        end
    end

    // stage 3: blend sum over influences with saturation
    logic signed [35:0] bsum [NW];
    logic signed [31:0] blend3_reg [NW];
    logic signed [31:0] pos3_reg [3];
    logic signed [31:0] nrm3_reg [3];

    always_comb begin
        for (int e = 0; e < NW; e++) begin
            bsum[e] = '0;
            for (int k = 0; k < NI; k++) begin
                bsum[e] = bsum[e] + 36'(wsh2_reg[k][e]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int e = 0; e < NW; e++) begin
                blend3_reg[e] <= lbvs_pkg::sat32_36(bsum[e]);
            end
            pos3_reg <= pos2_reg;
            nrm3_reg <= nrm2_reg;
        end
    end

    // stage 4: matrix times position and normal, floor shift by fraction
    logic signed [63:0] pprod [3][3];
    logic signed [63:0] nprod [3][3];
    logic signed [63:0] psh4_reg [3][3];
    logic signed [63:0] nsh4_reg [3][3];
    logic signed [31:0] tr4_reg  [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                pprod[r][c] = blend3_reg[r*4 + c] * pos3_reg[c];
                nprod[r][c] = blend3_reg[r*4 + c] * nrm3_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    psh4_reg[r][c] <= pprod[r][c] >>> FRAC_BITS;
                    nsh4_reg[r][c] <= nprod[r][c] >>> FRAC_BITS;
                end
                tr4_reg[r] <= blend3_reg[r*4 + 3];
            end
        end
    end

    // stage 5: row sums, translation, saturation into the output register
    logic signed [65:0] psum [3];
    logic signed [65:0] nsum [3];
    logic signed [31:0] opos_reg [3];
    logic signed [31:0] onrm_reg [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            psum[r] = 66'(tr4_reg[r]);
            nsum[r] = '0;
            for (int c = 0; c < 3; c++) begin
                psum[r] = psum[r] + 66'(psh4_reg[r][c]);
                nsum[r] = nsum[r] + 66'(nsh4_reg[r][c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int r = 0; r < 3; r++) begin
                opos_reg[r] <= lbvs_pkg::sat32_66(psum[r]);
                onrm_reg[r] <= lbvs_pkg::sat32_66(nsum[r]);
            end
        end
    end

    assign m_valid     = v_reg[NST];
    assign m_out_pos_x = opos_reg[0];
    assign m_out_pos_y = opos_reg[1];
    assign m_out_pos_z = opos_reg[2];
    assign m_out_nrm_x = onrm_reg[0];
    assign m_out_nrm_y = onrm_reg[1];
    assign m_out_nrm_z = onrm_reg[2];

endmodule
